>>> rtl/bsa_pkg.sv
// bsa_pkg: shared constants, status codes and types of the bitmap slot allocator.
// Used by bsa_map, bsa_word_eval and bitmap_slot_allocator; depends on nothing.

package bsa_pkg;

	// Slot map geometry: one memory word holds the used bits of 32 slots
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;

	// Field widths
	localparam int CAP_W   = 9;
	localparam int SLOT_W  = 12;
	localparam int GRANT_W = 8;
	localparam int STAT_W  = 3;

	// Defaults
	localparam int DEFAULT_SLOTS = 256;
	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	// Low space: 20*(free+1) <= capacity, that is free < capacity/20 rounded down
	localparam int LOW_DIV = 20;

	// Request kinds
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
	localparam logic [STAT_W-1:0] ST_ZERO     = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOTALLOC = 3'd4;

	// Result of evaluating one map word
	typedef struct packed {
		logic             found;     // a free in-range slot exists in the word
		logic [BIT_W-1:0] free_bit;  // lowest such slot within the word
		logic             sel_used;  // used bit of the selected slot
	} eval_t;

endpackage

>>> rtl/bsa_map.sv
// bsa_map: slot bitmap memory, one 32-bit word per address, registered read.
// Per-word valid bits make a cleared or never-written word read as zero.
// Depends on bsa_pkg.

module bsa_map import bsa_pkg::*; #(
	parameter int NWORDS = 8,
	parameter int WIDX_W = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic              rd_en,
	input  logic [WIDX_W-1:0] rd_addr,
	output logic [WORD_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [WIDX_W-1:0] wr_addr,
	input  logic [WORD_W-1:0] wr_data
);

	logic [WORD_W-1:0] mem [NWORDS];
	logic [NWORDS-1:0] vld_q;
	logic [WORD_W-1:0] rd_data_q;
	logic              rd_vld_q;

	// Word storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Valid bits: cleared at once, set on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

>>> rtl/bsa_word_eval.sv
// bsa_word_eval: shared word evaluator, reused each cycle of a search or check.
// Masks slots at or beyond capacity, finds the lowest free one, tests a bit.
// Depends on bsa_pkg.

module bsa_word_eval import bsa_pkg::*; #(
	parameter int WIDX_W = 3
) (
	input  logic [WORD_W-1:0] word,
	input  logic [WIDX_W-1:0] word_idx,
	input  logic [CAP_W-1:0]  cap,
	input  logic [BIT_W-1:0]  bit_sel,
	output eval_t             result
);

	logic [WORD_W-1:0] in_range;
	logic [WORD_W-1:0] avail;
	logic [SLOT_W-1:0] w_ext;
	logic [SLOT_W-1:0] cap_word;

	// Slots of this word that lie below capacity
	always_comb begin
		w_ext    = SLOT_W'(word_idx);
		cap_word = SLOT_W'(cap >> BIT_W);
		if (w_ext < cap_word) begin
			in_range = '1;
		end else if (w_ext == cap_word) begin
			in_range = (WORD_W'(1) << cap[BIT_W-1:0]) - WORD_W'(1);
		end else begin
			in_range = '0;
		end
		avail = ~word & in_range;
	end

	// Lowest free slot: priority encoder, low index wins
	always_comb begin
		result.found    = |avail;
		result.free_bit = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (avail[i]) begin
				result.free_bit = BIT_W'(i);
			end
		end
		result.sel_used = word[bit_sel];
	end

endmodule

>>> rtl/bitmap_slot_allocator.sv
// bitmap_slot_allocator: first-fit slot allocator over a bitmap of used slots.
//
// Requests arrive on the s_ stream: tuser carries the request kind (allocate
// or free), tdata the slot to free. Each request gives one result item on the
// m_ stream: tuser the status, tdata the granted slot, the low space flag and
// the free slots left. The capacity register is written on the cfg channel,
// only while no request is in flight; a write clears the whole map.
//
// One request at a time. An allocate reads the map one 32-bit word per cycle
// through a single read port and evaluator and scans at most SLOTS/32 words,
// rounded up (eight at the default size). A free reads the word of its slot,
// then checks the bit and clears it if set; a refused free and a full
// allocate go straight to the result. s_tready is high only between
// requests, so a new request waits until the previous one has finished.
// Reset clears the map (per-word valid bits), the used count and sets the
// capacity to 256. A finished result waits in the output register while
// m_tready is low; the next request may be accepted meanwhile and is held
// at its last step until the output register frees up.
// Depends on bsa_pkg, bsa_map and bsa_word_eval.

module bitmap_slot_allocator import bsa_pkg::*; #(
	parameter int SLOTS = DEFAULT_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] slot_to_free, [15:12] zero
	input  logic [0:0]  s_tuser,   // [0] op
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] granted_slot, [8] low_space, [17:9] remaining, zero above
	output logic [2:0]  m_tuser,   // [2:0] status
	// capacity register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data
);

	localparam int NWORDS = (SLOTS + WORD_W - 1) / WORD_W;
	localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam logic [WIDX_W-1:0] LAST_W = WIDX_W'(NWORDS - 1);
	localparam logic [CAP_W-1:0] CAP_MAX =
		CAP_W'((SLOTS > (1 << CAP_W) - 1) ? (1 << CAP_W) - 1 : SLOTS);
	localparam int THR_W = CAP_W + 5;

	// Sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_CHECK = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0]         state_q;
	logic [CAP_W-1:0]   capacity_q;
	logic [CAP_W-1:0]   used_q;
	logic [WIDX_W-1:0]  w_q;
	logic [BIT_W-1:0]   bit_q;
	logic [STAT_W-1:0]  status_q;
	logic [GRANT_W-1:0] granted_q;
	logic               low_q;
	logic               m_tvalid_q;
	logic [23:0]        m_tdata_q;
	logic [2:0]         m_tuser_q;

	logic               accept;
	logic               cfg_wr;
	logic               fin_load;
	logic               in_op;
	logic [SLOT_W-1:0]  in_slot;
	logic [CAP_W-1:0]   cap_eff;
	logic [CAP_W-1:0]   free_before;
	logic [CAP_W-1:0]   remaining;
	logic [THR_W-1:0]   low_thr;
	logic               low_now;

	logic               rd_en;
	logic [WIDX_W-1:0]  rd_addr;
	logic [WORD_W-1:0]  rd_data;
	logic               wr_en;
	logic [WORD_W-1:0]  wr_data;
	eval_t              ev;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign fin_load  = (state_q == S_FIN) && (!m_tvalid_q || m_tready);
	assign in_op     = s_tuser[0];
	assign in_slot   = s_tdata[SLOT_W-1:0];

	// Effective capacity, free count and low space test
	always_comb begin
		cap_eff     = (capacity_q > CAP_MAX) ? CAP_MAX : capacity_q;
		free_before = (cap_eff > used_q) ? cap_eff - used_q : '0;
		remaining   = free_before;
		low_thr     = THR_W'((32'(free_before) + 32'd1) * LOW_DIV);
		low_now     = (low_thr <= THR_W'(cap_eff));
	end

	// Slot map and the shared word evaluator
	bsa_map #(
		.NWORDS (NWORDS),
		.WIDX_W (WIDX_W)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (cfg_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (w_q),
		.wr_data (wr_data)
	);

	bsa_word_eval #(
		.WIDX_W (WIDX_W)
	) u_eval (
		.word     (rd_data),
		.word_idx (w_q),
		.cap      (cap_eff),
		.bit_sel  (bit_q),
		.result   (ev)
	);

	// Map port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = w_q;
		wr_en   = 1'b0;
		wr_data = rd_data;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					rd_en   = 1'b1;
					rd_addr = (in_op == OP_FREE) ? WIDX_W'(in_slot >> BIT_W) : '0;
				end
			end
			S_SCAN: begin
				if (ev.found) begin
					wr_en   = 1'b1;
					wr_data = rd_data | (WORD_W'(1) << ev.free_bit);
				end else if (w_q != LAST_W) begin
					rd_en   = 1'b1;
					rd_addr = w_q + 1'b1;
				end
			end
			S_CHECK: begin
				if (ev.sel_used) begin
					wr_en   = 1'b1;
					wr_data = rd_data & ~(WORD_W'(1) << bit_q);
				end
			end
			default: ;
		endcase
	end

	// Sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			capacity_q <= CAP_RESET;
			used_q     <= '0;
			w_q        <= '0;
			bit_q      <= '0;
			status_q   <= ST_OK;
			granted_q  <= '0;
			low_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else begin
			// Result valid: set on load, cleared once taken
			if (fin_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_wr) begin
				capacity_q <= cfg_data;
				used_q     <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						granted_q <= '0;
						bit_q     <= in_slot[BIT_W-1:0];
						if (in_op == OP_ALLOC) begin
							w_q <= '0;
							if (free_before == '0) begin
								status_q <= ST_FULL;
								low_q    <= 1'b0;
								state_q  <= S_FIN;
							end else begin
								status_q <= ST_OK;
								low_q    <= low_now;
								state_q  <= S_SCAN;
							end
						end else begin
							w_q   <= WIDX_W'(in_slot >> BIT_W);
							low_q <= 1'b0;
							priority if (in_slot >= SLOT_W'(cap_eff)) begin
								status_q <= ST_RANGE;
								state_q  <= S_FIN;
							end else if (in_slot == '0) begin
								status_q <= ST_ZERO;
								state_q  <= S_FIN;
							end else begin
								status_q <= ST_OK;
								state_q  <= S_CHECK;
							end
						end
					end
				end
				S_SCAN: begin
					if (ev.found) begin
						granted_q <= GRANT_W'({w_q, ev.free_bit});
						used_q    <= used_q + 1'b1;
						state_q   <= S_FIN;
					end else if (w_q == LAST_W) begin
						status_q <= ST_FULL;
						low_q    <= 1'b0;
						state_q  <= S_FIN;
					end else begin
						w_q <= w_q + 1'b1;
					end
				end
				S_CHECK: begin
					if (ev.sel_used) begin
						if (used_q != '0) begin
							used_q <= used_q - 1'b1;
						end
					end else begin
						status_q <= ST_NOTALLOC;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_load) begin
						m_tuser_q <= status_q;
						m_tdata_q <= {6'b0, remaining, low_q, granted_q};
						state_q   <= S_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Used count never exceeds the effective capacity
	a_used_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= cap_eff)
		else $error("used count above capacity");

	// A refused or full result never carries a granted slot
	a_no_grant_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[7:0] == '0))
		else $error("granted slot on a refused request");

	// A slot found by the search lies below capacity
	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && ev.found) |->
		(16'({w_q, ev.free_bit}) < 16'(cap_eff)))
		else $error("search found a slot beyond capacity");

	// The search steps one word per cycle
	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && !ev.found && w_q != LAST_W) |=>
		(w_q == $past(w_q) + 1'b1))
		else $error("search skipped a word");

endmodule
